// ===== rtl/intercom_pulse_width_frame_sender_assert.svh =====
// assertion macros for the intercom pulse width frame sender
`ifndef INTERCOM_PULSE_WIDTH_FRAME_SENDER_ASSERT_SVH
`define INTERCOM_PULSE_WIDTH_FRAME_SENDER_ASSERT_SVH

// same-cycle implication
`define IPW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("ipw assertion failed");

// next-cycle implication
`define IPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("ipw assertion failed");

`endif

// ===== rtl/ipw_pkg.sv =====
// package with shared types and constants of the frame sender
package ipw_pkg;

  localparam int unsigned CfgW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned MsgW    = 32;
  localparam int unsigned BitsW   = 6;

  localparam logic [CfgIdxW-1:0] RegStartTicks = 2'd0;
  localparam logic [CfgIdxW-1:0] RegOneTicks   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegZeroTicks  = 2'd2;

  localparam logic [CfgW-1:0] StartTicksRst = 16'd6000;
  localparam logic [CfgW-1:0] OneTicksRst   = 16'd4000;
  localparam logic [CfgW-1:0] ZeroTicksRst  = 16'd2000;

  localparam logic [MsgW-1:0]  ShortMsgMax = 32'h0000_FFFF;
  localparam logic [BitsW-1:0] BitsShort   = 6'd16;
  localparam logic [BitsW-1:0] BitsLong    = 6'd32;

  typedef enum logic [4:0] {
    PhIdle   = 5'b00001,
    PhStart  = 5'b00010,
    PhFlag   = 5'b00100,
    PhData   = 5'b01000,
    PhParity = 5'b10000
  } phase_e;

  typedef struct packed {
    logic            send;
    logic [MsgW-1:0] message;
  } item_t;

  typedef struct packed {
    logic valid;
    logic pop;
  } q_ctrl_t;

endpackage

// ===== rtl/ipw_if.sv =====
// item channel interfaces for the frame sender
interface ipw_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] message;

  modport source (output valid, output cmd, output message, input ready);
  modport sink (input valid, input cmd, input message, output ready);
endinterface

interface ipw_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic accepted;
  logic frame_done;

  modport source (output valid, output line_level, output busy_res, output accepted,
                  output frame_done, input ready);
  modport sink (input valid, input line_level, input busy_res, input accepted,
                input frame_done, output ready);
endinterface

// ===== rtl/ipw_front.sv =====
// input stage: accepts items and queues them for the sequencer
`include "intercom_pulse_width_frame_sender_assert.svh"

module ipw_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             in_cmd_i,
  input  logic [31:0]      in_message_i,
  output ipw_pkg::item_t   item_o,
  output ipw_pkg::q_ctrl_t ctrl_o,
  input  logic             pop_i
);

  ipw_pkg::item_t mem_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push;
  logic           pop;

  assign in_ready_o = (count_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = pop_i && (count_q != 2'd0);

  assign item_o       = mem_q[rd_ptr_q];
  assign ctrl_o.valid = (count_q != 2'd0);
  assign ctrl_o.pop   = pop;

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q].send    <= in_cmd_i;
      mem_q[wr_ptr_q].message <= in_message_i;
    end
  end

  `IPW_ASSERT_NOW(a_count_max, clk_i, rst_ni, 1'b1, count_q <= 2'd2)
  `IPW_ASSERT_NOW(a_ptr_track, clk_i, rst_ni, count_q == 2'd0 || count_q == 2'd2,
                  wr_ptr_q == rd_ptr_q)
  `IPW_ASSERT_NEXT(a_push_holds, clk_i, rst_ni, push && !pop, count_q != 2'd0)

endmodule

// ===== rtl/ipw_back.sv =====
// sequencer: runs the frame segments, holds the timing registers and the result register
`include "intercom_pulse_width_frame_sender_assert.svh"

module ipw_back #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [ipw_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [ipw_pkg::CfgW-1:0]      cfg_data_i,
  input  ipw_pkg::item_t                item_i,
  input  ipw_pkg::q_ctrl_t              ctrl_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          line_level_o,
  output logic                          busy_res_o,
  output logic                          accepted_o,
  output logic                          frame_done_o
);

  logic [ipw_pkg::CfgW-1:0] start_ticks_q, one_ticks_q, zero_ticks_q;

  ipw_pkg::phase_e                phase_q, phase_d;
  logic [ipw_pkg::BitsW-1:0]      bits_left_q, bits_left_d;
  logic [ipw_pkg::MsgW-1:0]       shift_q, shift_d;
  logic                           parity_q, parity_d;
  logic [TIMER_WIDTH-1:0]         timer_q, timer_d;
  logic                           drive_q, drive_d;

  logic                           out_valid_q;
  logic                           line_q, busy_q, acc_q, done_q;
  logic                           acc_d, done_d;

  logic [TIMER_WIDTH-1:0]         timer_dec;
  logic [ipw_pkg::BitsW-1:0]      bits_dec;
  logic                           data_bit;

  function automatic logic [TIMER_WIDTH-1:0] load_dur(logic [ipw_pkg::CfgW-1:0] ticks);
    logic [TIMER_WIDTH-1:0] t;
    t = TIMER_WIDTH'(ticks);
    return (t == '0) ? TIMER_WIDTH'(1) : t;
  endfunction

  assign pop_o     = ctrl_i.valid && (!out_valid_q || out_ready_i);
  assign timer_dec = timer_q - TIMER_WIDTH'(1);
  assign bits_dec  = bits_left_q - ipw_pkg::BitsW'(1);
  assign data_bit  = shift_q[bits_dec[4:0]];

  always_comb begin
    phase_d     = phase_q;
    bits_left_d = bits_left_q;
    shift_d     = shift_q;
    parity_d    = parity_q;
    timer_d     = timer_q;
    drive_d     = drive_q;
    acc_d       = 1'b0;
    done_d      = 1'b0;
    if (item_i.send) begin
      if (phase_q == ipw_pkg::PhIdle) begin
        acc_d       = 1'b1;
        shift_d     = item_i.message;
        bits_left_d = (item_i.message > ipw_pkg::ShortMsgMax) ? ipw_pkg::BitsLong
                                                              : ipw_pkg::BitsShort;
        parity_d    = 1'b1;
        drive_d     = 1'b1;
        timer_d     = load_dur(start_ticks_q);
        phase_d     = ipw_pkg::PhStart;
      end
    end else if (phase_q != ipw_pkg::PhIdle) begin
      timer_d = timer_dec;
      if (timer_dec == '0) begin
        case (phase_q)
          ipw_pkg::PhStart: begin
            drive_d = ~drive_q;
            timer_d = load_dur((bits_left_q == ipw_pkg::BitsLong) ? one_ticks_q
                                                                  : zero_ticks_q);
            phase_d = ipw_pkg::PhFlag;
          end
          ipw_pkg::PhFlag, ipw_pkg::PhData: begin
            if (phase_q == ipw_pkg::PhFlag || bits_left_q != '0) begin
              bits_left_d = bits_dec;
              parity_d    = parity_q ^ data_bit;
              drive_d     = ~drive_q;
              timer_d     = load_dur(data_bit ? one_ticks_q : zero_ticks_q);
              phase_d     = ipw_pkg::PhData;
            end else begin
              drive_d = ~drive_q;
              timer_d = load_dur(parity_q ? one_ticks_q : zero_ticks_q);
              phase_d = ipw_pkg::PhParity;
            end
          end
          ipw_pkg::PhParity: begin
            drive_d     = 1'b0;
            phase_d     = ipw_pkg::PhIdle;
            bits_left_d = '0;
            timer_d     = '0;
            done_d      = 1'b1;
          end
          default: begin
            phase_d = ipw_pkg::PhIdle;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_ticks_q <= ipw_pkg::StartTicksRst;
      one_ticks_q   <= ipw_pkg::OneTicksRst;
      zero_ticks_q  <= ipw_pkg::ZeroTicksRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        ipw_pkg::RegStartTicks: start_ticks_q <= cfg_data_i;
        ipw_pkg::RegOneTicks:   one_ticks_q   <= cfg_data_i;
        ipw_pkg::RegZeroTicks:  zero_ticks_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= ipw_pkg::PhIdle;
      bits_left_q <= '0;
      shift_q     <= '0;
      parity_q    <= 1'b1;
      timer_q     <= '0;
      drive_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop_o) begin
        phase_q     <= phase_d;
        bits_left_q <= bits_left_d;
        shift_q     <= shift_d;
        parity_q    <= parity_d;
        timer_q     <= timer_d;
        drive_q     <= drive_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      line_q  <= drive_d;
      busy_q  <= (phase_d != ipw_pkg::PhIdle);
      acc_q   <= acc_d;
      done_q  <= done_d;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign line_level_o = line_q;
  assign busy_res_o   = busy_q;
  assign accepted_o   = acc_q;
  assign frame_done_o = done_q;

  `IPW_ASSERT_NOW(a_idle_quiet, clk_i, rst_ni, phase_q == ipw_pkg::PhIdle,
                  bits_left_q == '0 && !drive_q)
  `IPW_ASSERT_NOW(a_bits_range, clk_i, rst_ni, 1'b1, bits_left_q <= ipw_pkg::BitsLong)
  `IPW_ASSERT_NOW(a_accept_drives, clk_i, rst_ni, out_valid_q && acc_q,
                  busy_q && line_q && !done_q)
  `IPW_ASSERT_NOW(a_done_low, clk_i, rst_ni, out_valid_q && done_q, !busy_q && !line_q)
  `IPW_ASSERT_NEXT(a_pop_fills, clk_i, rst_ni, pop_o, out_valid_q)
  `IPW_ASSERT_NOW(a_pop_agree, clk_i, rst_ni, 1'b1, ctrl_i.pop == pop_o)

endmodule

// ===== rtl/intercom_pulse_width_frame_sender.sv =====
// top level of the intercom pulse width frame sender
//
//  channel  dir  handshake      payload
//  in_if    in   valid/ready    cmd, message
//  out_if   out  valid/ready    line_level, busy_res, accepted, frame_done
//  cfg      in   cfg_we_i       cfg_idx_i, cfg_data_i
//
// one item per clock sustained while out_if takes results; each item passes through
// the input queue and then the sequencer result register before it leaves
// the sequencer counts its segment timer down once per tick item (cmd low) while a frame runs,
// rst_ni low clears the queue and the sequencer state and reloads the default durations
// a stalled out_if holds the result; the two-entry queue keeps taking items until full
module intercom_pulse_width_frame_sender #(
  parameter int unsigned TIMER_WIDTH = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [ipw_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [ipw_pkg::CfgW-1:0]    cfg_data_i,
  ipw_in_if.sink                      in_if,
  ipw_out_if.source                   out_if
);

  ipw_pkg::item_t   item;
  ipw_pkg::q_ctrl_t q_ctrl;
  logic             pop;

  ipw_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_if.valid),
    .in_ready_o   (in_if.ready),
    .in_cmd_i     (in_if.cmd),
    .in_message_i (in_if.message),
    .item_o       (item),
    .ctrl_o       (q_ctrl),
    .pop_i        (pop)
  );

  ipw_back #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .item_i       (item),
    .ctrl_i       (q_ctrl),
    .pop_o        (pop),
    .out_valid_o  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .line_level_o (out_if.line_level),
    .busy_res_o   (out_if.busy_res),
    .accepted_o   (out_if.accepted),
    .frame_done_o (out_if.frame_done)
  );

endmodule

// ===== tb/sv/intercom_pulse_width_frame_sender_tb.sv =====
// testbench for the intercom pulse width frame sender: per-item line prediction and checking
module intercom_pulse_width_frame_sender_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TimerW     = 16;
  localparam int unsigned RunLimit   = 3_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned ChunkItems = 56;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic accepted;
    logic frame_done;
  } line_state_t;

  class frame_line_board;
    logic [ipw_pkg::CfgW-1:0]  start_len;
    logic [ipw_pkg::CfgW-1:0]  one_len;
    logic [ipw_pkg::CfgW-1:0]  zero_len;
    ipw_pkg::phase_e           seg_kind;
    logic [ipw_pkg::BitsW-1:0] bits_left;
    logic [ipw_pkg::MsgW-1:0]  shift_word;
    logic                      parity;
    logic [TimerW-1:0]         seg_timer;
    logic                      level;
    line_state_t               line_forecast[$];
    int unsigned               mismatches;
    int unsigned               results_seen;
    int unsigned               items_taken;
    int unsigned               frames_sent;
    int unsigned               frames_ended;
    int unsigned               sends_refused;

    function new();
      start_len     = ipw_pkg::StartTicksRst;
      one_len       = ipw_pkg::OneTicksRst;
      zero_len      = ipw_pkg::ZeroTicksRst;
      seg_kind      = ipw_pkg::PhIdle;
      bits_left     = '0;
      shift_word    = '0;
      parity        = 1'b1;
      seg_timer     = '0;
      level         = 1'b0;
      mismatches    = 0;
      results_seen  = 0;
      items_taken   = 0;
      frames_sent   = 0;
      frames_ended  = 0;
      sends_refused = 0;
    endfunction

    function void set_duration(logic [ipw_pkg::CfgIdxW-1:0] idx,
                               logic [ipw_pkg::CfgW-1:0] value);
      case (idx)
        ipw_pkg::RegStartTicks: start_len = value;
        ipw_pkg::RegOneTicks:   one_len = value;
        ipw_pkg::RegZeroTicks:  zero_len = value;
        default: ;
      endcase
    endfunction

    function bit is_busy();
      return seg_kind != ipw_pkg::PhIdle;
    endfunction

    // a duration that is zero after the cut to timer width still lasts one tick
    function logic [TimerW-1:0] seg_len(logic [ipw_pkg::CfgW-1:0] ticks);
      logic [TimerW-1:0] t;
      t = TimerW'(ticks);
      return (t == '0) ? TimerW'(1) : t;
    endfunction

    function logic [TimerW-1:0] bit_len(logic b);
      return seg_len(b ? one_len : zero_len);
    endfunction

    function void shift_out_bit();
      logic b;
      b = shift_word[5'(bits_left - ipw_pkg::BitsW'(1))];
      bits_left = bits_left - ipw_pkg::BitsW'(1);
      parity ^= b;
      level = ~level;
      seg_timer = bit_len(b);
      seg_kind = ipw_pkg::PhData;
    endfunction

    function void take_item(logic cmd, logic [ipw_pkg::MsgW-1:0] msg);
      line_state_t r;
      r = '0;
      items_taken++;
      if (cmd) begin
        if (seg_kind == ipw_pkg::PhIdle) begin
          r.accepted = 1'b1;
          frames_sent++;
          shift_word = msg;
          bits_left = (msg > ipw_pkg::ShortMsgMax) ? ipw_pkg::BitsLong : ipw_pkg::BitsShort;
          parity = 1'b1;
          level = 1'b1;
          seg_timer = seg_len(start_len);
          seg_kind = ipw_pkg::PhStart;
        end else begin
          sends_refused++;
        end
      end else if (seg_kind != ipw_pkg::PhIdle) begin
        seg_timer = seg_timer - TimerW'(1);
        if (seg_timer == '0) begin
          case (seg_kind)
            ipw_pkg::PhStart: begin
              level = ~level;
              seg_timer = bit_len(bits_left == ipw_pkg::BitsLong);
              seg_kind = ipw_pkg::PhFlag;
            end
            ipw_pkg::PhFlag: shift_out_bit();
            ipw_pkg::PhData: begin
              if (bits_left != '0) begin
                shift_out_bit();
              end else begin
                level = ~level;
                seg_timer = bit_len(parity);
                seg_kind = ipw_pkg::PhParity;
              end
            end
            default: begin
              level = 1'b0;
              seg_kind = ipw_pkg::PhIdle;
              bits_left = '0;
              seg_timer = '0;
              r.frame_done = 1'b1;
              frames_ended++;
            end
          endcase
        end
      end
      r.line_level = level;
      r.busy_res = (seg_kind != ipw_pkg::PhIdle);
      line_forecast.push_back(r);
    endfunction

    task report(string text);
      mismatches++;
      $display("mismatch at result %0d: %s", results_seen, text);
    endtask

    task match_result(line_state_t got);
      line_state_t want;
      results_seen++;
      if (line_forecast.size() == 0) begin
        report("result with no item waiting");
        return;
      end
      want = line_forecast.pop_front();
      if (got.line_level !== want.line_level)
        report($sformatf("line_level got %b want %b", got.line_level, want.line_level));
      if (got.busy_res !== want.busy_res)
        report($sformatf("busy_res got %b want %b", got.busy_res, want.busy_res));
      if (got.accepted !== want.accepted)
        report($sformatf("accepted got %b want %b", got.accepted, want.accepted));
      if (got.frame_done !== want.frame_done)
        report($sformatf("frame_done got %b want %b", got.frame_done, want.frame_done));
    endtask
  endclass

  logic                        clk_i = 1'b0;
  logic                        rst_ni = 1'b0;
  logic                        cfg_we;
  logic [ipw_pkg::CfgIdxW-1:0] cfg_idx;
  logic [ipw_pkg::CfgW-1:0]    cfg_data;

  ipw_in_if  item_ch ();
  ipw_out_if res_ch ();

  intercom_pulse_width_frame_sender #(
    .TIMER_WIDTH(TimerW)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .in_if      (item_ch),
    .out_if     (res_ch)
  );

  frame_line_board board = new();

  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;
  int unsigned holds_asked;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && item_ch.valid && item_ch.ready) begin
      board.take_item(item_ch.cmd, item_ch.message);
    end
    if (rst_ni && res_ch.valid && res_ch.ready) begin
      board.match_result(line_state_t'{res_ch.line_level, res_ch.busy_res,
                                       res_ch.accepted, res_ch.frame_done});
    end
  end

  initial begin : receiver
    int unsigned hold_left;
    int unsigned holds_done;
    res_ch.ready = 1'b0;
    hold_left = 0;
    holds_done = 0;
    forever begin
      @(negedge clk_i);
      if (holds_done != holds_asked) begin
        holds_done = holds_asked;
        hold_left = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < RunLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic push_item(logic cmd, logic [ipw_pkg::MsgW-1:0] msg);
    while ($urandom_range(99) < tx_idle_pct) begin
      item_ch.valid <= 1'b0;
      item_ch.message <= $urandom;
      @(negedge clk_i);
    end
    item_ch.valid <= 1'b1;
    item_ch.cmd <= cmd;
    item_ch.message <= msg;
    do begin
      @(posedge clk_i);
    end while (item_ch.ready !== 1'b1);
    @(negedge clk_i);
  endtask

  task automatic settle();
    item_ch.valid <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (board.line_forecast.size() != 0);
  endtask

  task automatic finish_frame();
    while (board.is_busy()) begin
      push_item(1'b0, $urandom);
    end
    settle();
  endtask

  task automatic write_reg(logic [ipw_pkg::CfgIdxW-1:0] idx, logic [ipw_pkg::CfgW-1:0] value);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= value;
    board.set_duration(idx, value);
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_durations(logic [ipw_pkg::CfgW-1:0] s, logic [ipw_pkg::CfgW-1:0] o,
                               logic [ipw_pkg::CfgW-1:0] z);
    write_reg(ipw_pkg::RegStartTicks, s);
    write_reg(ipw_pkg::RegOneTicks, o);
    write_reg(ipw_pkg::RegZeroTicks, z);
  endtask

  function automatic logic [ipw_pkg::CfgW-1:0] rand_len();
    return ($urandom_range(9) == 0) ? ipw_pkg::CfgW'($urandom_range(12))
                                    : ipw_pkg::CfgW'($urandom_range(3));
  endfunction

  // mostly frame starts while idle and ticks while busy, some refused sends
  task automatic random_items(int unsigned count);
    int unsigned done;
    logic [ipw_pkg::MsgW-1:0] msg;
    logic cmd;
    done = 0;
    while (done < count) begin
      case ($urandom_range(12))
        0: msg = '0;
        1: msg = ipw_pkg::ShortMsgMax;
        2: msg = ipw_pkg::ShortMsgMax + ipw_pkg::MsgW'(1);
        3: msg = '1;
        4, 5, 6: msg = ipw_pkg::MsgW'($urandom_range(ipw_pkg::ShortMsgMax));
        default: msg = $urandom;
      endcase
      if (board.is_busy()) cmd = ($urandom_range(99) < 4);
      else cmd = ($urandom_range(99) < 70);
      if (cmd != board.is_busy()) done++;
      push_item(cmd, msg);
    end
  endtask

  task automatic random_phase(int unsigned chunks);
    repeat (chunks) begin
      finish_frame();
      set_durations(rand_len(), rand_len(), rand_len());
      random_items(ChunkItems);
    end
  endtask

  initial begin : stimulus
    item_ch.valid = 1'b0;
    item_ch.cmd = 1'b0;
    item_ch.message = '0;
    cfg_we = 1'b0;
    cfg_idx = ipw_pkg::RegStartTicks;
    cfg_data = '0;
    tx_idle_pct = 21;
    rx_idle_pct = 82;
    holds_asked = 0;
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // ticks while idle, then a short frame with refused sends
    set_durations(ipw_pkg::CfgW'(3), ipw_pkg::CfgW'(2), ipw_pkg::CfgW'(1));
    push_item(1'b0, '1);
    push_item(1'b0, '0);
    push_item(1'b1, '0);
    push_item(1'b1, '1);
    push_item(1'b0, $urandom);
    push_item(1'b1, ipw_pkg::ShortMsgMax + ipw_pkg::MsgW'(1));
    finish_frame();

    // zero durations count as one tick
    set_durations(ipw_pkg::CfgW'(1), '0, '0);
    push_item(1'b1, '1);
    push_item(1'b1, '0);
    finish_frame();
    set_durations('0, ipw_pkg::CfgW'(2), ipw_pkg::CfgW'(1));
    push_item(1'b1, ipw_pkg::ShortMsgMax);
    finish_frame();
    push_item(1'b1, ipw_pkg::ShortMsgMax + ipw_pkg::MsgW'(1));
    push_item(1'b0, '1);
    finish_frame();

    random_phase(4);

    tx_idle_pct = 82;
    rx_idle_pct = 21;
    random_phase(4);

    // long output stall while items keep coming
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    holds_asked++;
    random_items(ChunkItems);
    random_phase(3);

    // longer segments
    finish_frame();
    set_durations(ipw_pkg::CfgW'(40), ipw_pkg::CfgW'(1), ipw_pkg::CfgW'(1));
    push_item(1'b1, '0);
    finish_frame();
    set_durations(ipw_pkg::CfgW'(1), ipw_pkg::CfgW'(1), ipw_pkg::CfgW'(40));
    push_item(1'b1, ipw_pkg::ShortMsgMax);
    finish_frame();
    set_durations(ipw_pkg::CfgW'(1), ipw_pkg::CfgW'(40), ipw_pkg::CfgW'(1));
    push_item(1'b1, ipw_pkg::ShortMsgMax + ipw_pkg::MsgW'(1));
    finish_frame();

    repeat (8) @(negedge clk_i);
    $display("run covered %0d items: %0d frames started, %0d ended, %0d sends refused",
             board.items_taken, board.frames_sent, board.frames_ended, board.sends_refused);
    $display("checked %0d results under three idling patterns and a %0d-cycle output stall",
             board.results_seen, HoldCycles);
    if (board.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
